>>> rtl/slwm_pkg.sv
// ----------------------------------------------------------------------------
// Sound level window monitor package
// Shared widths, codes, configuration struct and pipeline transfer structs.
// ----------------------------------------------------------------------------
`default_nettype none

package slwm_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned BLOCKS_W  = 7;
  localparam int unsigned POINTS_W  = 8;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ALARM_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Opcodes of an input item.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE              = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTICE_VOLUME       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOUD_VOLUME         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LED_THRESHOLD       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_COUNT       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_COUNT         = 3'd7;

  // Alarm codes.
  localparam logic [ALARM_W-1:0] ALARM_QUIET   = 2'd0;
  localparam logic [ALARM_W-1:0] ALARM_WARNING = 2'd1;
  localparam logic [ALARM_W-1:0] ALARM_ALARM   = 2'd2;

  // Score points per block.
  localparam logic [POINTS_W-1:0] SCORE_NONE    = 8'd0;
  localparam logic [POINTS_W-1:0] SCORE_WARNING = 8'd1;
  localparam logic [POINTS_W-1:0] SCORE_TRIGGER = 8'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_MIN_INIT = 16'hFFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX_INIT = 16'h0000;
  localparam logic [BYTE_W-1:0]  LED_SAT       = 8'hFF;

  // Configuration register reset values.
  localparam logic                RST_ENABLE              = 1'b1;
  localparam logic [LEVEL_W-1:0]  RST_BLOCK_LIMIT         = 16'd500;
  localparam logic [BLOCKS_W-1:0] RST_BLOCKS_PER_INTERVAL = 7'd10;
  localparam logic [LEVEL_W-1:0]  RST_NOTICE_VOLUME       = 16'h2710;
  localparam logic [LEVEL_W-1:0]  RST_LOUD_VOLUME         = 16'h4B00;
  localparam logic [TOTAL_W-1:0]  RST_LED_THRESHOLD       = 16'd25;
  localparam logic [TOTAL_W-1:0]  RST_WARNING_COUNT       = 16'd100;
  localparam logic [TOTAL_W-1:0]  RST_ALARM_COUNT         = 16'd200;

  typedef struct packed {
    logic                enable;
    logic [LEVEL_W-1:0]  block_limit;
    logic [BLOCKS_W-1:0] blocks_per_interval;
    logic [LEVEL_W-1:0]  notice_volume;
    logic [LEVEL_W-1:0]  loud_volume;
    logic [TOTAL_W-1:0]  led_threshold;
    logic [TOTAL_W-1:0]  warning_count;
    logic [TOTAL_W-1:0]  alarm_count;
  } cfg_t;

  // Pipeline control handed to every stage.
  typedef struct packed {
    logic adv;    // whole pipeline moves on this edge
    logic step1;  // item accepted into the front stage
    logic step2;  // valid transfer in the volume stage
    logic step3;  // valid transfer in the scoring stage
    logic step4;  // valid transfer in the window stage
  } pipe_ctl_t;

  // Front stage to volume stage: a block close carries its extremes.
  typedef struct packed {
    logic               clr;
    logic               close;
    logic [LEVEL_W-1:0] vmax;
    logic [LEVEL_W-1:0] vmin;
  } blk_tok_t;

  typedef struct packed {
    logic               clr;
    logic               close;
    logic [LEVEL_W-1:0] volume;
  } vol_tok_t;

  typedef struct packed {
    logic                clr;
    logic                close_int;
    logic [POINTS_W-1:0] points;
    logic [BYTE_W-1:0]   vol_byte;
  } pts_tok_t;

  typedef struct packed {
    logic              close_int;
    logic [BYTE_W-1:0] vol_byte;
  } win_tok_t;

endpackage

`default_nettype wire

>>> rtl/slwm_block.sv
// ----------------------------------------------------------------------------
// Block tracker
// Tracks the minimum and maximum sample of the running block and the sample
// counter, and flags the item that closes a block.
// ----------------------------------------------------------------------------
`default_nettype none

module slwm_block import slwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctl_t          ctl,
  input  cfg_t               cfg,
  input  logic               opcode,
  input  logic [LEVEL_W-1:0] sample_level,
  output blk_tok_t           tok
);

  logic [LEVEL_W-1:0] sample_counter;
  logic [LEVEL_W-1:0] level_min;
  logic [LEVEL_W-1:0] level_max;
  logic [LEVEL_W-1:0] sample_counter_next;
  logic [LEVEL_W-1:0] level_min_next;
  logic [LEVEL_W-1:0] level_max_next;
  logic [LEVEL_W-1:0] hi;
  logic [LEVEL_W-1:0] lo;
  blk_tok_t           tok_next;

  // Extremes including this sample, and the update of the block state.
  always_comb begin
    hi = (sample_level > level_max) ? sample_level : level_max;
    lo = (sample_level < level_min) ? sample_level : level_min;
    sample_counter_next = sample_counter;
    level_min_next      = level_min;
    level_max_next      = level_max;
    tok_next.clr   = (opcode == OP_CLEAR);
    tok_next.close = 1'b0;
    tok_next.vmax  = hi;
    tok_next.vmin  = lo;
    if (opcode == OP_CLEAR) begin
      level_min_next = LEVEL_MIN_INIT;
      level_max_next = LEVEL_MAX_INIT;
    end else if (cfg.enable) begin
      if (sample_counter >= cfg.block_limit) begin
        tok_next.close      = 1'b1;
        sample_counter_next = '0;
        level_min_next      = LEVEL_MIN_INIT;
        level_max_next      = LEVEL_MAX_INIT;
      end else begin
        sample_counter_next = sample_counter + LEVEL_W'(1);
        level_min_next      = lo;
        level_max_next      = hi;
      end
    end
  end

  // Block state changes only on an accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      level_min      <= LEVEL_MIN_INIT;
      level_max      <= LEVEL_MAX_INIT;
    end else if (ctl.step1) begin
      sample_counter <= sample_counter_next;
      level_min      <= level_min_next;
      level_max      <= level_max_next;
    end
  end

  // Pipeline register towards the volume stage.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      tok <= tok_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slwm_score.sv
// ----------------------------------------------------------------------------
// Volume and scoring stages
// Forms the peak-to-peak volume of a closed block, scores it and sums the
// points of each interval.
// ----------------------------------------------------------------------------
`default_nettype none

module slwm_score import slwm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pipe_ctl_t ctl,
  input  cfg_t      cfg,
  input  blk_tok_t  blk,
  output pts_tok_t  tok
);

  vol_tok_t            vol;
  logic [LEVEL_W-1:0]  last_volume;
  logic [POINTS_W-1:0] interval_points;
  logic [BLOCKS_W-1:0] blocks_in_interval;
  logic [LEVEL_W-1:0]  last_volume_next;
  logic [POINTS_W-1:0] interval_points_next;
  logic [BLOCKS_W-1:0] blocks_in_interval_next;
  logic [POINTS_W-1:0] score;
  logic [POINTS_W-1:0] points_sum;
  logic [BLOCKS_W-1:0] blocks_sum;
  pts_tok_t            tok_next;

  // Volume stage: peak-to-peak of the block, modulo the level width.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      vol.clr    <= blk.clr;
      vol.close  <= blk.close;
      vol.volume <= blk.vmax - blk.vmin;
    end
  end

  // Scoring stage: points of the block and the interval count.
  always_comb begin
    if (vol.volume > cfg.loud_volume) begin
      score = SCORE_TRIGGER;
    end else if (vol.volume > cfg.notice_volume) begin
      score = SCORE_WARNING;
    end else begin
      score = SCORE_NONE;
    end
    points_sum = interval_points + score;
    blocks_sum = blocks_in_interval + BLOCKS_W'(1);

    last_volume_next        = last_volume;
    interval_points_next    = interval_points;
    blocks_in_interval_next = blocks_in_interval;
    tok_next.clr       = vol.clr;
    tok_next.close_int = 1'b0;
    tok_next.points    = points_sum;
    if (vol.clr) begin
      last_volume_next        = '0;
      interval_points_next    = '0;
      blocks_in_interval_next = '0;
    end else if (vol.close) begin
      last_volume_next = vol.volume;
      if (blocks_sum >= cfg.blocks_per_interval) begin
        tok_next.close_int      = 1'b1;
        interval_points_next    = '0;
        blocks_in_interval_next = '0;
      end else begin
        interval_points_next    = points_sum;
        blocks_in_interval_next = blocks_sum;
      end
    end
    tok_next.vol_byte = last_volume_next[LEVEL_W-1 -: BYTE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_volume        <= '0;
      interval_points    <= '0;
      blocks_in_interval <= '0;
    end else if (ctl.step3) begin
      last_volume        <= last_volume_next;
      interval_points    <= interval_points_next;
      blocks_in_interval <= blocks_in_interval_next;
    end
  end

  // Pipeline register towards the window stage.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      tok <= tok_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slwm_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds the points of one past interval and hands them to its neighbour when
// a new interval enters the window.
// ----------------------------------------------------------------------------
`default_nettype none

module slwm_cell import slwm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                clr,
  input  logic                shift,
  input  logic [POINTS_W-1:0] d,
  output logic [POINTS_W-1:0] q
);

  // An emptied window holds zero in every cell.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slwm_window.sv
// ----------------------------------------------------------------------------
// Interval window
// A row of cells holding the last intervals, oldest at the far end, and the
// running window total.
// ----------------------------------------------------------------------------
`default_nettype none

module slwm_window import slwm_pkg::*; #(
  parameter int unsigned WINDOW_INTERVALS = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctl_t          ctl,
  input  pts_tok_t           pts,
  output win_tok_t           tok,
  output logic [TOTAL_W-1:0] window_total
);

  logic [POINTS_W-1:0] cell_q [WINDOW_INTERVALS];
  logic [TOTAL_W-1:0]  window_total_next;
  logic                clr;
  logic                shift;

  assign clr   = ctl.step4 && pts.clr;
  assign shift = ctl.step4 && pts.close_int;

  // Cell 0 takes the new interval; the last cell drops the oldest one.
  for (genvar i = 0; i < WINDOW_INTERVALS; i++) begin : g_cell
    if (i == 0) begin : g_head
      slwm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .clr   (clr),
        .shift (shift),
        .d     (pts.points),
        .q     (cell_q[i])
      );
    end else begin : g_body
      slwm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .clr   (clr),
        .shift (shift),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  // Running total: drop the oldest interval, add the new one.
  assign window_total_next = window_total
                           - TOTAL_W'(cell_q[WINDOW_INTERVALS-1])
                           + TOTAL_W'(pts.points);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      window_total <= '0;
    end else if (shift) begin
      window_total <= window_total_next;
    end
  end

  // Pipeline register towards the output stage.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      tok.close_int <= pts.close_int && !pts.clr;
      tok.vol_byte  <= pts.vol_byte;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sound_level_window_monitor.sv
// The monitor takes one transfer per clock cycle while in_stall is low and
// gives one result for each. The block tracking register is loaded at the
// transfer itself; the volume subtraction, scoring, window update and output
// registers follow it in that order. The window is a row of cells that shifts
// by one place at each interval close, so a clear item empties it at once and
// there is no clearing pass after reset.
// The pipeline moves as a whole; it stalls the input only while a result is
// held in the output register.
// ----------------------------------------------------------------------------
// Sound level window monitor, top level
// Configuration registers, pipeline control, window and alarm output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_level_window_monitor import slwm_pkg::*; #(
  parameter int unsigned WINDOW_INTERVALS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [LEVEL_W-1:0]   sample_level,
  // Output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    volume_byte,
  output logic [ALARM_W-1:0]   alarm_level,
  output logic                 led_update,
  output logic [BYTE_W-1:0]    led_level
);

  cfg_t               cfg;
  pipe_ctl_t          ctl;
  logic               adv;
  logic               v1;
  logic               v2;
  logic               v3;
  logic               v4;
  blk_tok_t           blk_tok;
  pts_tok_t           pts_tok;
  win_tok_t           win_tok;
  logic [TOTAL_W-1:0] window_total;
  logic [ALARM_W-1:0] alarm_next;
  logic [BYTE_W-1:0]  led_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable              <= RST_ENABLE;
      cfg.block_limit         <= RST_BLOCK_LIMIT;
      cfg.blocks_per_interval <= RST_BLOCKS_PER_INTERVAL;
      cfg.notice_volume       <= RST_NOTICE_VOLUME;
      cfg.loud_volume         <= RST_LOUD_VOLUME;
      cfg.led_threshold       <= RST_LED_THRESHOLD;
      cfg.warning_count       <= RST_WARNING_COUNT;
      cfg.alarm_count         <= RST_ALARM_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:              cfg.enable              <= cfg_data[0];
        REG_BLOCK_LIMIT:         cfg.block_limit         <= cfg_data;
        REG_BLOCKS_PER_INTERVAL: cfg.blocks_per_interval <= cfg_data[BLOCKS_W-1:0];
        REG_NOTICE_VOLUME:       cfg.notice_volume       <= cfg_data;
        REG_LOUD_VOLUME:         cfg.loud_volume         <= cfg_data;
        REG_LED_THRESHOLD:       cfg.led_threshold       <= cfg_data;
        REG_WARNING_COUNT:       cfg.warning_count       <= cfg_data;
        REG_ALARM_COUNT:         cfg.alarm_count         <= cfg_data;
        default:                 cfg.enable              <= cfg.enable;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  assign ctl.adv   = adv;
  assign ctl.step1 = in_valid && adv;
  assign ctl.step2 = v1 && adv;
  assign ctl.step3 = v2 && adv;
  assign ctl.step4 = v3 && adv;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  slwm_block u_block (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg          (cfg),
    .opcode       (opcode),
    .sample_level (sample_level),
    .tok          (blk_tok)
  );

  slwm_score u_score (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cfg (cfg),
    .blk (blk_tok),
    .tok (pts_tok)
  );

  slwm_window #(
    .WINDOW_INTERVALS (WINDOW_INTERVALS)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .pts          (pts_tok),
    .tok          (win_tok),
    .window_total (window_total)
  );

  // Alarm level and LED level from the window total.
  always_comb begin
    if (window_total > cfg.alarm_count) begin
      alarm_next = ALARM_ALARM;
    end else if (window_total > cfg.warning_count) begin
      alarm_next = ALARM_WARNING;
    end else begin
      alarm_next = ALARM_QUIET;
    end
    if (!win_tok.close_int || !(window_total > cfg.led_threshold)) begin
      led_next = '0;
    end else if (window_total[TOTAL_W-1:BYTE_W+1] != '0) begin
      led_next = LED_SAT;
    end else begin
      led_next = window_total[BYTE_W:1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      volume_byte <= win_tok.vol_byte;
      alarm_level <= alarm_next;
      led_update  <= win_tok.close_int;
      led_level   <= led_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slwm_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports and flags results that break the contract.
// ----------------------------------------------------------------------------
`default_nettype none

module slwm_checker import slwm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [BYTE_W-1:0]  volume_byte,
  input logic [ALARM_W-1:0] alarm_level,
  input logic               led_update,
  input logic [BYTE_W-1:0]  led_level
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(volume_byte)
      && $stable(alarm_level) && $stable(led_update) && $stable(led_level))
    else $error("stalled result changed");

  // With the output register empty the input is never stalled.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // A result that closes no interval carries no LED level.
  a_led_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !led_update |-> led_level == '0)
    else $error("LED level without an interval close");

  // The alarm code never takes the unused value.
  a_alarm_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alarm_level == ALARM_QUIET || alarm_level == ALARM_WARNING
      || alarm_level == ALARM_ALARM)
    else $error("alarm level out of range");

  // No result appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind sound_level_window_monitor slwm_checker u_slwm_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sound level window monitor testbench
// Sends samples and clear items through the input channel with random gaps,
// stalls the output channel at random, and checks every result against a
// cycle-free model of the block-extremes, scoring and interval window logic.
// A short directed list comes first, then randomised phases, each with its
// own register settings, written while the pipeline is empty.
// ----------------------------------------------------------------------------

module tb_top import slwm_pkg::*; ();

  localparam int unsigned WINDOW_LEN  = 40;
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned LOUD_PHASE  = 2;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned HOLD_CYCLES = 100;

  typedef struct packed {
    logic [BYTE_W-1:0]  vol_byte;
    logic [ALARM_W-1:0] alarm;
    logic               led_update;
    logic [BYTE_W-1:0]  led;
  } level_report_t;

  localparam level_report_t QUIET_REPORT =
    '{vol_byte: '0, alarm: ALARM_QUIET, led_update: 1'b0, led: '0};

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic                 op;
    logic [LEVEL_W-1:0]   value;
    bit                   literal;
    level_report_t        want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 opcode;
  logic [LEVEL_W-1:0]   sample_level;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    volume_byte;
  logic [ALARM_W-1:0]   alarm_level;
  logic                 led_update;
  logic [BYTE_W-1:0]    led_level;

  // Expected results in order of input transfer, and run bookkeeping.
  level_report_t report_q[$];
  stim_row_t     directed_rows[$];
  int unsigned   mismatches = 0;
  int unsigned   taken = 0;
  int unsigned   stuck_cycles = 0;

  // Shadow of the registers and of the monitor state.
  cfg_t                cfg_shadow;
  logic [LEVEL_W-1:0]  pr_count;
  logic [LEVEL_W-1:0]  pr_min;
  logic [LEVEL_W-1:0]  pr_max;
  logic [LEVEL_W-1:0]  pr_volume;
  logic [BLOCKS_W-1:0] pr_blocks;
  logic [POINTS_W-1:0] pr_points;
  logic [TOTAL_W-1:0]  pr_total;
  logic [POINTS_W-1:0] pr_cells [WINDOW_LEN];
  int unsigned         pr_pos;

  always #6 clk = ~clk;

  sound_level_window_monitor #(
    .WINDOW_INTERVALS(WINDOW_LEN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .sample_level (sample_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .volume_byte  (volume_byte),
    .alarm_level  (alarm_level),
    .led_update   (led_update),
    .led_level    (led_level)
  );

  // Empties the window and the block tracking; the sample counter is kept.
  function automatic void clear_window_shadow();
    pr_volume = '0;
    pr_min    = LEVEL_MIN_INIT;
    pr_max    = LEVEL_MAX_INIT;
    pr_blocks = '0;
    pr_points = '0;
    pr_pos    = 0;
    pr_total  = '0;
    foreach (pr_cells[i]) pr_cells[i] = '0;
  endfunction

  // Applies one input item to the shadow state and returns its result.
  function automatic level_report_t advance_monitor(input logic op,
                                                    input logic [LEVEL_W-1:0] lvl);
    level_report_t      rep;
    logic [TOTAL_W-1:0] half;
    logic [BYTE_W-1:0]  led;
    logic               closed;
    led    = '0;
    closed = 1'b0;
    if (op == OP_CLEAR) begin
      clear_window_shadow();
    end else if (cfg_shadow.enable) begin
      if (lvl > pr_max) pr_max = lvl;
      if (lvl < pr_min) pr_min = lvl;
      if (pr_count >= cfg_shadow.block_limit) begin
        // Block close: score the peak-to-peak volume.
        pr_volume = pr_max - pr_min;
        if (pr_volume > cfg_shadow.loud_volume) begin
          pr_points = pr_points + SCORE_TRIGGER;
        end else if (pr_volume > cfg_shadow.notice_volume) begin
          pr_points = pr_points + SCORE_WARNING;
        end
        pr_blocks = pr_blocks + BLOCKS_W'(1);
        if (pr_blocks >= cfg_shadow.blocks_per_interval) begin
          // Interval close: the oldest window entry is replaced.
          pr_total = pr_total - TOTAL_W'(pr_cells[pr_pos]) + TOTAL_W'(pr_points);
          pr_cells[pr_pos] = pr_points;
          if (pr_total > cfg_shadow.led_threshold) begin
            half = pr_total >> 1;
            led  = (half > 16'd255) ? LED_SAT : half[BYTE_W-1:0];
          end
          pr_pos    = (pr_pos == WINDOW_LEN - 1) ? 0 : pr_pos + 1;
          pr_points = '0;
          pr_blocks = '0;
          closed    = 1'b1;
        end
        pr_count = '0;
        pr_min   = LEVEL_MIN_INIT;
        pr_max   = LEVEL_MAX_INIT;
      end else begin
        pr_count = pr_count + LEVEL_W'(1);
      end
    end
    if (pr_total > cfg_shadow.alarm_count) begin
      rep.alarm = ALARM_ALARM;
    end else if (pr_total > cfg_shadow.warning_count) begin
      rep.alarm = ALARM_WARNING;
    end else begin
      rep.alarm = ALARM_QUIET;
    end
    rep.vol_byte   = pr_volume[LEVEL_W-1:BYTE_W];
    rep.led_update = closed;
    rep.led        = closed ? led : '0;
    return rep;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [LEVEL_W-1:0] value);
    stim_row_t row;
    row.kind    = ROW_WRITE;
    row.idx     = idx;
    row.op      = OP_SAMPLE;
    row.value   = value;
    row.literal = 1'b0;
    row.want    = QUIET_REPORT;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic op, input logic [LEVEL_W-1:0] value,
                                   input bit literal);
    stim_row_t row;
    row.kind    = ROW_ITEM;
    row.idx     = REG_ENABLE;
    row.op      = op;
    row.value   = value;
    row.literal = literal;
    row.want    = QUIET_REPORT;
    directed_rows.push_back(row);
  endfunction

  // Lowers valid and waits until every expected result has been taken.
  task automatic drain_reports();
    @(negedge clk) in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [LEVEL_W-1:0] value);
    drain_reports();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:              cfg_shadow.enable              = value[0];
      REG_BLOCK_LIMIT:         cfg_shadow.block_limit         = value;
      REG_BLOCKS_PER_INTERVAL: cfg_shadow.blocks_per_interval = value[BLOCKS_W-1:0];
      REG_NOTICE_VOLUME:       cfg_shadow.notice_volume       = value;
      REG_LOUD_VOLUME:         cfg_shadow.loud_volume         = value;
      REG_LED_THRESHOLD:       cfg_shadow.led_threshold       = value;
      REG_WARNING_COUNT:       cfg_shadow.warning_count       = value;
      REG_ALARM_COUNT:         cfg_shadow.alarm_count         = value;
      default: ;
    endcase
  endtask

  // Offers one item, waits for its transfer, records the expected result and
  // then idles for a random gap unless the caller asks for back-to-back items.
  task automatic send_item(input logic op, input logic [LEVEL_W-1:0] lvl,
                           input bit literal, input level_report_t want,
                           input bit burst);
    level_report_t predicted;
    int unsigned   r;
    int unsigned   gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    opcode       <= op;
    sample_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_monitor(op, lvl);
    report_q.push_back(literal ? want : predicted);
    gap = 0;
    if (!burst) begin
      r = $urandom_range(0, 99);
      if (r >= 95) begin
        gap = $urandom_range(8, 30);
      end else if (r >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Output side: random stalls with quiet stretches, and one long hold-off
  // so that the pipeline fills up and stalls the input.
  initial begin : stall_gen
    int unsigned stall_left;
    int unsigned mode_left;
    int unsigned r;
    bit          quiet_mode;
    bit          held;
    out_stall  = 1'b0;
    stall_left = 0;
    mode_left  = 0;
    quiet_mode = 1'b0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && taken >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        quiet_mode = ($urandom_range(0, 2) == 0);
        mode_left  = $urandom_range(30, 120);
      end else begin
        mode_left--;
      end
      if (stall_left == 0 && !quiet_mode) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 23) begin
          stall_left = $urandom_range(8, 25);
        end
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    level_report_t got;
    level_report_t want;
    if (!rst && out_valid && !out_stall) begin
      taken++;
      got = '{vol_byte: volume_byte, alarm: alarm_level, led_update: led_update,
              led: led_level};
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with no transfer pending: vol %0h alarm %0d upd %0b led %0h",
                   got.vol_byte, got.alarm, got.led_update, got.led);
        end
      end else begin
        want = report_q.pop_front();
        if (got.vol_byte !== want.vol_byte || got.alarm !== want.alarm ||
            got.led_update !== want.led_update || got.led !== want.led) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected vol %0h alarm %0d upd %0b led %0h,",
                     want.vol_byte, want.alarm, want.led_update, want.led,
                     " got vol %0h alarm %0d upd %0b led %0h",
                     got.vol_byte, got.alarm, got.led_update, got.led);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("sound_level_window_monitor regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Main stimulus.
  initial begin : stimulus
    logic [LEVEL_W-1:0]  limit;
    logic [BLOCKS_W-1:0] bpi;
    logic [LEVEL_W-1:0]  warn_lvl;
    logic [LEVEL_W-1:0]  trig_lvl;
    logic [TOTAL_W-1:0]  led_thr;
    logic [TOTAL_W-1:0]  warn_cnt;
    logic [TOTAL_W-1:0]  alarm_cnt;
    logic                en;
    logic                op;
    logic [LEVEL_W-1:0]  lvl;
    int unsigned         n_items;
    int unsigned         r;
    bit                  clears;
    bit                  burst;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_ENABLE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    opcode       = OP_SAMPLE;
    sample_level = '0;

    cfg_shadow = '{enable: RST_ENABLE, block_limit: RST_BLOCK_LIMIT,
                   blocks_per_interval: RST_BLOCKS_PER_INTERVAL,
                   notice_volume: RST_NOTICE_VOLUME, loud_volume: RST_LOUD_VOLUME,
                   led_threshold: RST_LED_THRESHOLD, warning_count: RST_WARNING_COUNT,
                   alarm_count: RST_ALARM_COUNT};
    pr_count = '0;
    clear_window_shadow();

    // Directed list. Out of reset nothing has closed, so results are quiet.
    add_item(OP_SAMPLE, 16'h0000, 1'b1);
    add_item(OP_SAMPLE, 16'hFFFF, 1'b1);
    add_item(OP_CLEAR,  16'hFFFF, 1'b1);
    // Zero limit and zero blocks per interval: every sample closes both.
    add_write(REG_BLOCK_LIMIT, 16'd0);
    add_write(REG_BLOCKS_PER_INTERVAL, 16'd0);
    add_write(REG_LED_THRESHOLD, 16'd0);
    add_item(OP_SAMPLE, 16'h1234, 1'b0);
    // Two-sample blocks, one block per interval, trigger and warning scores.
    add_write(REG_BLOCK_LIMIT, 16'd1);
    add_write(REG_BLOCKS_PER_INTERVAL, 16'd1);
    add_write(REG_NOTICE_VOLUME, 16'd0);
    add_write(REG_LOUD_VOLUME, 16'hFFFE);
    add_write(REG_WARNING_COUNT, 16'd0);
    add_write(REG_ALARM_COUNT, 16'd1);
    add_item(OP_SAMPLE, 16'h0000, 1'b0);
    add_item(OP_SAMPLE, 16'hFFFF, 1'b0);
    add_item(OP_SAMPLE, 16'h8000, 1'b0);
    add_item(OP_SAMPLE, 16'h8001, 1'b0);
    // Samples while disabled leave the state alone.
    add_write(REG_ENABLE, 16'd0);
    add_item(OP_SAMPLE, 16'h0000, 1'b0);
    add_item(OP_SAMPLE, 16'hFFFF, 1'b0);
    // Full-scale volume does not exceed full-scale levels.
    add_write(REG_ENABLE, 16'd1);
    add_write(REG_LOUD_VOLUME, 16'hFFFF);
    add_write(REG_NOTICE_VOLUME, 16'hFFFF);
    add_item(OP_SAMPLE, 16'h0000, 1'b0);
    add_item(OP_SAMPLE, 16'hFFFF, 1'b0);
    // A clear empties the window and the block tracking, enabled or not; the sample counter is kept.
    add_item(OP_CLEAR, 16'h0000, 1'b1);
    add_write(REG_ENABLE, 16'd0);
    add_item(OP_CLEAR, 16'hAAAA, 1'b1);
    // Largest settings: no block closes within a couple of samples.
    add_write(REG_ENABLE, 16'd1);
    add_write(REG_BLOCKS_PER_INTERVAL, 16'd127);
    add_write(REG_LED_THRESHOLD, 16'hFFFF);
    add_write(REG_WARNING_COUNT, 16'hFFFF);
    add_write(REG_ALARM_COUNT, 16'hFFFF);
    add_write(REG_BLOCK_LIMIT, 16'hFFFF);
    add_item(OP_SAMPLE, 16'h5555, 1'b0);
    add_item(OP_SAMPLE, 16'hAAAA, 1'b0);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].value,
                  directed_rows[i].literal, directed_rows[i].want, 1'b0);
      end
    end

    // Random phases, each with a fresh set of registers.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      if (ph == LOUD_PHASE) begin
        // Every two-sample block of nonzero volume scores two points, so the window
        // total climbs past the LED saturation point.
        en        = 1'b1;
        limit     = 16'd1;
        bpi       = 7'd16;
        warn_lvl  = 16'($urandom);
        trig_lvl  = 16'd0;
        led_thr   = 16'($urandom_range(0, 40));
        warn_cnt  = 16'($urandom_range(0, 400));
        alarm_cnt = 16'($urandom_range(300, 700));
        n_items   = 540;
        clears    = 1'b0;
        burst     = 1'b1;
      end else begin
        en = ($urandom_range(0, 7) != 0);
        r  = $urandom_range(0, 9);
        limit = (r == 0) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 6))
                                           : 16'($urandom_range(7, 40));
        r   = $urandom_range(0, 9);
        bpi = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(1, 5));
        r   = $urandom_range(0, 7);
        warn_lvl = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        r   = $urandom_range(0, 7);
        trig_lvl = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        led_thr   = 16'($urandom_range(0, 10));
        warn_cnt  = 16'($urandom_range(0, 16));
        alarm_cnt = 16'($urandom_range(0, 30));
        n_items   = 28;
        clears    = 1'b1;
        burst     = ($urandom_range(0, 2) == 0);
      end
      // Unused upper bits of the narrow registers carry noise.
      write_reg(REG_ENABLE, {15'($urandom), en});
      write_reg(REG_BLOCK_LIMIT, limit);
      write_reg(REG_BLOCKS_PER_INTERVAL, {9'($urandom), bpi});
      write_reg(REG_NOTICE_VOLUME, warn_lvl);
      write_reg(REG_LOUD_VOLUME, trig_lvl);
      write_reg(REG_LED_THRESHOLD, led_thr);
      write_reg(REG_WARNING_COUNT, warn_cnt);
      write_reg(REG_ALARM_COUNT, alarm_cnt);

      for (int unsigned i = 0; i < n_items; i++) begin
        op = (clears && $urandom_range(0, 39) == 0) ? OP_CLEAR : OP_SAMPLE;
        r  = $urandom_range(0, 15);
        lvl = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        send_item(op, lvl, 1'b0, QUIET_REPORT, burst);
      end
    end

    drain_reports();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("sound_level_window_monitor regression: pass");
    end else begin
      $display("sound_level_window_monitor regression: fail");
    end
    $finish;
  end

endmodule
